>>> src/ure_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package ure_pkg;

  // One input beat: a microsecond tick with the sampled echo and a start request.
  typedef struct packed {
    logic start_req;
    logic echo_level;
  } ure_in_t;

  // One result beat, produced for every input tick.
  typedef struct packed {
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic       no_echo;
    logic [9:0] distance_cm;
    logic       near;
  } ure_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [9:0]  near_threshold_cm;
    logic [15:0] edge_timeout_us;
    logic [15:0] width_cap_us;
  } ure_cfg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_THRESHOLD = 2'd0,
    CFG_EDGE_TIMEOUT   = 2'd1,
    CFG_WIDTH_CAP      = 2'd2
  } ure_cfg_idx_t;

  localparam logic [9:0]  NEAR_THRESHOLD_RESET = 10'd10;
  localparam logic [15:0] EDGE_TIMEOUT_RESET   = 16'd30000;
  localparam logic [15:0] WIDTH_CAP_RESET      = 16'd60000;

  // Distance is width * 34 / 2000 = width * 17 / 1000. The division is a
  // multiply by ceil(17 * 2^26 / 1000) followed by a 26-bit shift, exact
  // for every 16-bit width.
  localparam int          WIDTH_W    = 16;
  localparam int          RECIP_W    = 21;
  localparam int          DIST_SHIFT = 26;
  localparam int          PROD_W     = WIDTH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1140851;
  localparam int          RAW_DIST_W = PROD_W - DIST_SHIFT;
  localparam logic [9:0]  DIST_MAX   = 10'd1023;

endpackage

>>> src/ure_cfg.sv
// Configuration register file for the ultrasonic echo ranger.
module ure_cfg
  import ure_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output ure_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_threshold_cm <= NEAR_THRESHOLD_RESET;
      cfg.edge_timeout_us   <= EDGE_TIMEOUT_RESET;
      cfg.width_cap_us      <= WIDTH_CAP_RESET;
    end else if (cfg_wr_en) begin
      unique case (ure_cfg_idx_t'(cfg_index))
        CFG_NEAR_THRESHOLD: cfg.near_threshold_cm <= cfg_wdata[9:0];
        CFG_EDGE_TIMEOUT:   cfg.edge_timeout_us   <= cfg_wdata;
        CFG_WIDTH_CAP:      cfg.width_cap_us      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> src/ure_dist.sv
// Width-to-distance conversion with saturation and the near compare.
module ure_dist
  import ure_pkg::*;
(
  input  logic [WIDTH_W-1:0] width,
  input  logic [9:0]         near_threshold_cm,
  output logic [9:0]         distance_cm,
  output logic               near
);

  logic [PROD_W-1:0]     prod;
  logic [RAW_DIST_W-1:0] raw_dist;

  assign prod     = PROD_W'(width) * PROD_W'(DIST_RECIP);
  assign raw_dist = prod[PROD_W-1:DIST_SHIFT];

  always_comb begin
    if (raw_dist > RAW_DIST_W'(DIST_MAX)) begin
      distance_cm = DIST_MAX;
    end else begin
      distance_cm = raw_dist[9:0];
    end
    near = (distance_cm < near_threshold_cm);
  end

endmodule

>>> src/ure_ctrl.sv
// Measurement sequencer: trigger pulse, edge waits and echo width count.
module ure_ctrl
  import ure_pkg::*;
#(
  parameter int TRIGGER_TICKS = 10
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  ure_in_t  in_data,
  input  ure_cfg_t cfg,
  output ure_out_t res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_WLOW  = 3'd3,
    PH_WRISE = 3'd4,
    PH_MEAS  = 3'd5
  } phase_t;

  phase_t             phase, phase_next;
  logic [WIDTH_W-1:0] phase_ticks, phase_ticks_next;
  logic [WIDTH_W-1:0] echo_width, echo_width_next;
  logic [WIDTH_W-1:0] tick_inc;
  logic               finish;
  logic               timed_out;
  logic [9:0]         distance;
  logic               dist_near;

  assign tick_inc = phase_ticks + WIDTH_W'(1);

  ure_dist u_dist (
    .width             (echo_width_next),
    .near_threshold_cm (cfg.near_threshold_cm),
    .distance_cm       (distance),
    .near              (dist_near)
  );

  always_comb begin
    phase_next       = phase;
    phase_ticks_next = phase_ticks;
    echo_width_next  = echo_width;
    finish           = 1'b0;
    timed_out        = 1'b0;
    res              = '0;
    res.busy_res     = 1'b1;

    unique case (phase)
      PH_TLOW: begin
        phase_next       = PH_THIGH;
        phase_ticks_next = '0;
      end
      PH_THIGH: begin
        res.trigger_level = 1'b1;
        if (tick_inc >= WIDTH_W'(TRIGGER_TICKS)) begin
          phase_next       = PH_WLOW;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = tick_inc;
        end
      end
      PH_WLOW: begin
        if (in_data.echo_level) begin
          phase_ticks_next = tick_inc;
        end else begin
          phase_next       = PH_WRISE;
          phase_ticks_next = WIDTH_W'(1);
        end
        if (phase_ticks_next >= cfg.edge_timeout_us) begin
          finish    = 1'b1;
          timed_out = 1'b1;
        end
      end
      PH_WRISE: begin
        if (!in_data.echo_level) begin
          phase_ticks_next = tick_inc;
          if (tick_inc >= cfg.edge_timeout_us) begin
            finish    = 1'b1;
            timed_out = 1'b1;
          end
        end else begin
          phase_next       = PH_MEAS;
          phase_ticks_next = '0;
          echo_width_next  = WIDTH_W'(1);
          if (WIDTH_W'(1) >= cfg.width_cap_us) begin
            finish = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (in_data.echo_level) begin
          echo_width_next = echo_width + WIDTH_W'(1);
          if (echo_width_next >= cfg.width_cap_us) begin
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
        if (in_data.start_req) begin
          phase_next       = PH_TLOW;
          phase_ticks_next = WIDTH_W'(1);
          echo_width_next  = '0;
        end else begin
          res.busy_res = 1'b0;
        end
      end
    endcase

    if (finish) begin
      res.busy_res     = 1'b0;
      res.done_res     = 1'b1;
      res.no_echo      = timed_out;
      res.distance_cm  = timed_out ? '0 : distance;
      res.near         = !timed_out && dist_near;
      phase_next       = PH_IDLE;
      phase_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_ticks <= '0;
      echo_width  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      phase_ticks <= phase_ticks_next;
      echo_width  <= echo_width_next;
    end
  end

`ifndef SYNTH
  // The trigger pulse never runs longer than its programmed tick count.
  a_thigh_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_THIGH |-> phase_ticks < WIDTH_W'(TRIGGER_TICKS))
    else $error("trigger high count ran past its length");

  // A measurement that finishes always returns to idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    step && finish |=> phase == PH_IDLE && phase_ticks == '0)
    else $error("finished measurement did not return to idle");

  // Without a step the sequencer state holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(phase_ticks) && $stable(echo_width))
    else $error("sequencer state moved without an input beat");
`endif

endmodule

>>> src/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: handshake, result register and assertions.
//
// The ranger takes one input beat per microsecond tick, carrying the sampled echo
// level and a start request, and returns exactly one result beat for each. An idle
// ranger that sees a start request drives the trigger low for two ticks and then
// high for TRIGGER_TICKS ticks, waits for the echo to go low and then to rise
// (each wait bounded by edge_timeout_us), and counts the echo-high ticks up to
// width_cap_us. The finishing beat carries done_res with either no_echo or the
// distance width*34/2000 cm (saturated at 1023) and a near flag. Throughput is one
// beat per clock while each waiting result is taken in the same cycle: the sequencer
// state and the width-to-distance multiplier sit between the input port and a single
// result register, so each result appears in the cycle after its input is accepted.
// The user must write configuration registers through the plain write port only
// while no measurement runs; the block does not enforce this.
module ultrasonic_echo_ranger_unit
  import ure_pkg::*;
#(
  parameter int TRIGGER_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ure_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ure_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ure_cfg_t cfg;
  ure_out_t res;
  logic     step;

  // The result register frees up when it is empty or being drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  ure_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ure_ctrl #(
    .TRIGGER_TICKS (TRIGGER_TICKS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_data (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  // The payload register needs no reset; only its valid flag is control state.
  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  // Every accepted input beat produces a result beat on the next cycle.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted beat produced no result");

  // A finishing beat is never also a busy beat.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done and busy raised together");

  // A timed-out measurement reports no distance and no near flag.
  a_no_echo_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_echo |->
      out_data.done_res && out_data.distance_cm == '0 && !out_data.near)
    else $error("no_echo beat carries a distance");

  // The trigger only fires during a measurement.
  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger_level |-> out_data.busy_res && !out_data.done_res)
    else $error("trigger driven outside a measurement");
`endif

endmodule

>>> sim/ure_ranging_checker.sv
// Checker for the ultrasonic echo ranger: predicts every result beat and compares it.
module ure_ranging_checker
  import ure_pkg::*;
#(
  parameter int TRIGGER_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  ure_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  ure_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output logic                  ranger_idle
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    RNG_IDLE,
    RNG_TRIG_LOW,
    RNG_TRIG_HIGH,
    RNG_WAIT_LOW,
    RNG_WAIT_RISE,
    RNG_MEASURE
  } ranger_phase_e;

  ranger_phase_e phase = RNG_IDLE;
  int unsigned   phase_ticks;
  int unsigned   echo_width;
  logic [9:0]    near_thr;
  logic [15:0]   edge_tmo;
  logic [15:0]   width_cap;
  ure_out_t      ranging_due[$];

  // Moves the ranger state by one tick and returns the result beat of that tick.
  function automatic ure_out_t advance_ranger(ure_in_t beat);
    ure_out_t    res;
    logic        finish;
    logic        timed_out;
    int unsigned dist_cm;
    res = '0;
    res.busy_res = 1'b1;
    finish = 1'b0;
    timed_out = 1'b0;
    case (phase)
      RNG_TRIG_LOW: begin
        phase = RNG_TRIG_HIGH;
        phase_ticks = 0;
      end
      RNG_TRIG_HIGH: begin
        res.trigger_level = 1'b1;
        phase_ticks++;
        if (phase_ticks >= TRIGGER_TICKS) begin
          phase = RNG_WAIT_LOW;
          phase_ticks = 0;
        end
      end
      RNG_WAIT_LOW: begin
        if (beat.echo_level) begin
          phase_ticks++;
        end else begin
          phase = RNG_WAIT_RISE;
          phase_ticks = 1;
        end
        if (phase_ticks >= edge_tmo) begin
          finish = 1'b1;
          timed_out = 1'b1;
        end
      end
      RNG_WAIT_RISE: begin
        if (!beat.echo_level) begin
          phase_ticks++;
          if (phase_ticks >= edge_tmo) begin
            finish = 1'b1;
            timed_out = 1'b1;
          end
        end else begin
          phase = RNG_MEASURE;
          phase_ticks = 0;
          echo_width = 1;
          if (echo_width >= width_cap) finish = 1'b1;
        end
      end
      RNG_MEASURE: begin
        if (beat.echo_level) begin
          echo_width++;
          if (echo_width >= width_cap) finish = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase = RNG_IDLE;
        phase_ticks = 0;
        if (beat.start_req) begin
          phase = RNG_TRIG_LOW;
          phase_ticks = 1;
          echo_width = 0;
        end else begin
          res.busy_res = 1'b0;
        end
      end
    endcase
    if (finish) begin
      res.busy_res = 1'b0;
      res.done_res = 1'b1;
      res.no_echo = timed_out;
      if (!timed_out) begin
        // The distance saturates at 1023 cm and the near flag sees the saturated value.
        dist_cm = echo_width * 34 / 2000;
        if (dist_cm > 1023) dist_cm = 1023;
        res.distance_cm = dist_cm[9:0];
        res.near = (dist_cm < near_thr);
      end
      phase = RNG_IDLE;
      phase_ticks = 0;
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ure_out_t want;
    if (rst) begin
      phase = RNG_IDLE;
      phase_ticks = 0;
      echo_width = 0;
      near_thr = NEAR_THRESHOLD_RESET;
      edge_tmo = EDGE_TIMEOUT_RESET;
      width_cap = WIDTH_CAP_RESET;
      ranging_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_NEAR_THRESHOLD: near_thr = cfg_wdata[9:0];
          CFG_EDGE_TIMEOUT:   edge_tmo = cfg_wdata;
          CFG_WIDTH_CAP:      width_cap = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) ranging_due.push_back(advance_ranger(in_data));
      if (out_valid && out_ready) begin
        if (ranging_due.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = ranging_due.pop_front();
          check_field("trigger_level", want.trigger_level, out_data.trigger_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("no_echo", want.no_echo, out_data.no_echo);
          check_field("distance_cm", want.distance_cm, out_data.distance_cm);
          check_field("near", want.near, out_data.near);
        end
      end
    end
    pending = ranging_due.size();
  end

  assign ranger_idle = (phase == RNG_IDLE);

endmodule

>>> sim/tb_ultrasonic_echo_ranger_unit.sv
// Testbench top for the ultrasonic echo ranger: stimulus, flow control and verdict.
module tb_ultrasonic_echo_ranger_unit
  import ure_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIG_TICKS = 10;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  // Length of the one long receiver hold-off that makes the block back up.
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS = 1000;
  localparam int RANDOM_PINGS = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  ure_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ure_out_t              out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   fail_count;
  int   pending;
  logic ranger_idle;

  // Flow-control knobs. The gap percentages change per phase so that some phases
  // run with no idling at all; quiet switches idling off for the closing part.
  int   tx_gap_pct = 10;
  int   rx_gap_pct = 10;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  bit   start_noise_on = 1'b1;
  int   beats_sent = 0;
  int   pings_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ultrasonic_echo_ranger_unit #(
    .TRIGGER_TICKS(TRIG_TICKS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ure_ranging_checker #(
    .TRIGGER_TICKS(TRIG_TICKS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .ranger_idle(ranger_idle)
  );

  // Offers one tick as a beat and returns at the falling edge after it was taken.
  // A random gap may come first; valid then rises together with the new payload.
  task automatic send_beat(bit start, bit echo);
    ure_in_t beat;
    beat.start_req = start;
    beat.echo_level = echo;
    if (!quiet && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Start requests sprinkled over a measurement; the ranger must ignore them.
  function automatic bit noise_start();
    return start_noise_on && ($urandom_range(0, 7) == 0);
  endfunction

  // One measurement as a sensor would answer it: the start beat, random echo
  // during the trigger pulse, then echo high (the low wait), echo low (the rise
  // wait), the echo pulse itself, and a low beat that closes the pulse.
  task automatic launch_ping(int unsigned pre_hi, int unsigned gap_lo, int unsigned width_hi);
    send_beat(1'b1, 1'($urandom_range(0, 1)));
    repeat (TRIG_TICKS + 1) send_beat(noise_start(), 1'($urandom_range(0, 1)));
    repeat (pre_hi) send_beat(noise_start(), 1'b1);
    repeat (gap_lo) send_beat(noise_start(), 1'b0);
    repeat (width_hi) send_beat(noise_start(), 1'b1);
    send_beat(noise_start(), 1'b0);
    pings_sent++;
  endtask

  // Brings the ranger back to idle with quiet beats, drops valid and waits until
  // every expected result beat has come out, so that registers may be written.
  task automatic settle();
    while (!ranger_idle) send_beat(1'b0, 1'b0);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all three registers. The bits above the 10-bit threshold carry junk
  // that the block has to mask off.
  task automatic configure(int unsigned thr, int unsigned tmo, int unsigned cap);
    cfg_write(CFG_NEAR_THRESHOLD, {6'($urandom_range(0, 63)), 10'(thr)});
    cfg_write(CFG_EDGE_TIMEOUT, 16'(tmo));
    cfg_write(CFG_WIDTH_CAP, 16'(cap));
  endtask

  // Receiver. Each falling edge sets ready exactly once. The long hold-off is
  // counted here while the sender keeps offering beats, so the single result
  // register fills up and the block has to stall its input.
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (burst_left != 0) begin
        out_ready <= 1'b0;
        burst_left--;
      end else if (!quiet && $urandom_range(1, 100) <= rx_gap_pct) begin
        out_ready <= 1'b0;
        burst_left = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned tmo;
    int unsigned cap;
    int unsigned thr;
    int unsigned pre;
    int unsigned gap;
    int unsigned wid;
    int          phase_no;
    int          waited;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Two idle beats first, one with the echo high, to show an
    // idle ranger without a start request stays idle whatever the echo does.
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    settle();
    // Largest threshold, a timeout of two ticks, a cap of one tick, and a
    // write to the unused index that must change nothing.
    configure(1023, 2, 1);
    cfg_write(CFG_IDX_SPARE, 16'hFFFF);
    // Start held high through a whole measurement: the extra requests are
    // ignored, including the one on the done beat. The echo falls and rises at
    // once and the first high sample already reaches the one-tick cap.
    send_beat(1'b1, 1'b0);
    repeat (TRIG_TICKS + 1) send_beat(1'b1, 1'($urandom_range(0, 1)));
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    // An echo that never falls: the low wait runs out and no_echo is reported.
    send_beat(1'b1, 1'b1);
    repeat (TRIG_TICKS + 1) send_beat(1'b0, 1'($urandom_range(0, 1)));
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);

    // Random part: phases of a few measurements each under a fresh setting.
    // Most phases are short so that timeouts and caps come up often; every
    // fourth phase allows longer pulses so that distances and the near flag move.
    phase_no = 0;
    while (beats_sent < RANDOM_BEATS || pings_sent < RANDOM_PINGS) begin
      settle();
      case ($urandom_range(0, 3))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 5;
        2:       tx_gap_pct = 15;
        default: tx_gap_pct = 30;
      endcase
      case ($urandom_range(0, 3))
        0:       rx_gap_pct = 0;
        1:       rx_gap_pct = 5;
        2:       rx_gap_pct = 15;
        default: rx_gap_pct = 30;
      endcase
      if (phase_no % 4 == 3) begin
        thr = $urandom_range(0, 4);
        tmo = $urandom_range(20, 60);
        cap = $urandom_range(60, 250);
      end else begin
        // Zero timeout or cap is allowed here and must act like one.
        thr = $urandom_range(0, 3);
        tmo = $urandom_range(0, 40);
        cap = $urandom_range(0, 60);
      end
      configure(thr, tmo, cap);
      if (phase_no == 1) hold_req = 1'b1;
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 4) == 0) begin
          // Broken shapes: waits may run out and the pulse may be cut anywhere.
          pre = $urandom_range(0, tmo + 2);
          gap = $urandom_range(0, tmo + 2);
          wid = $urandom_range(0, cap + 3);
        end else begin
          pre = $urandom_range(0, tmo / 2);
          gap = $urandom_range(1, tmo / 2 + 1);
          wid = $urandom_range(1, cap + 2);
        end
        launch_ping(pre, gap, wid);
        repeat ($urandom_range(0, 6)) send_beat(noise_start(), 1'($urandom_range(0, 1)));
      end
      phase_no++;
    end

    // Closing part with no idling: a threshold of 2 cm with widths just below
    // and just above it (1 cm near, 2 cm not near), then a pulse that runs
    // into the cap and keeps going while the ranger is already idle.
    quiet = 1'b1;
    start_noise_on = 1'b0;
    settle();
    configure(2, 100, 150);
    launch_ping(0, 3, 117);
    launch_ping(2, 1, 118);
    launch_ping(0, 1, 155);

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending != 0) begin
      $error("%0d expected result beats never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
